### hdl/cldsch_pkg.sv
// Shared types and codes for the C-LOOK disk request scheduler.
package cldsch_pkg;

  // Request type codes on the input channel
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_DONE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } cldsch_state_t;

  // Control from the sequencer to the selection unit
  typedef struct packed {
    logic clear;
    logic sample;
  } pick_ctl_t;

endpackage

### hdl/cldsch_ram.sv
// Generic simple dual-port RAM with registered read.
module cldsch_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/cldsch_pick.sv
// Selection unit: tracks same-cylinder, next-higher and lowest candidates over a slot scan.
module cldsch_pick
  import cldsch_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYLINDER_BITS = 14,
  parameter int TAG_BITS      = 8,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pick_ctl_t                ctl,
  input  logic [CYLINDER_BITS-1:0] head,
  input  logic [AW-1:0]            smp_idx,
  input  logic [CYLINDER_BITS-1:0] smp_cyl,
  input  logic [TAG_BITS-1:0]      smp_tag,
  output logic [AW-1:0]            sel_idx,
  output logic [CYLINDER_BITS-1:0] sel_cyl,
  output logic [TAG_BITS-1:0]      sel_tag
);

  logic                     eq_found_r, up_found_r, low_found_r;
  logic [AW-1:0]            eq_idx_r, up_idx_r, low_idx_r;
  logic [TAG_BITS-1:0]      eq_tag_r, up_tag_r, low_tag_r;
  logic [CYLINDER_BITS-1:0] up_cyl_r, low_cyl_r;
  logic                     take_eq, take_up, take_low;

  // slots arrive oldest first, so strict compares keep the oldest on ties
  assign take_eq  = ctl.sample && !eq_found_r && (smp_cyl == head);
  assign take_up  = ctl.sample && (smp_cyl > head) && (!up_found_r || smp_cyl < up_cyl_r);
  assign take_low = ctl.sample && (!low_found_r || smp_cyl < low_cyl_r);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      eq_found_r  <= 1'b0;
      up_found_r  <= 1'b0;
      low_found_r <= 1'b0;
    end else begin
      if (take_eq) begin
        eq_found_r <= 1'b1;
      end
      if (take_up) begin
        up_found_r <= 1'b1;
      end
      if (take_low) begin
        low_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_eq) begin
      eq_idx_r <= smp_idx;
      eq_tag_r <= smp_tag;
    end
    if (take_up) begin
      up_idx_r <= smp_idx;
      up_tag_r <= smp_tag;
      up_cyl_r <= smp_cyl;
    end
    if (take_low) begin
      low_idx_r <= smp_idx;
      low_tag_r <= smp_tag;
      low_cyl_r <= smp_cyl;
    end
  end

  always_comb begin
    if (eq_found_r) begin
      sel_idx = eq_idx_r;
      sel_cyl = head;
      sel_tag = eq_tag_r;
    end else if (up_found_r) begin
      sel_idx = up_idx_r;
      sel_cyl = up_cyl_r;
      sel_tag = up_tag_r;
    end else begin
      sel_idx = low_idx_r;
      sel_cyl = low_cyl_r;
      sel_tag = low_tag_r;
    end
  end

endmodule

### hdl/circular_look_disk_request_scheduler_unit.sv
// C-LOOK scheduler top level: sequencer, queue RAM, selection unit and result register.
// Flow: an arrival or an empty-queue done goes from accept through ST_RESULT into the
// output registers; a done choosing among queued requests runs the ST_SCAN slot scan,
// the ST_SHIFT compaction and the result load in ST_RESULT. in_stall stays high from
// accept to result load, so a new request is taken only once the last one is through.
// Reset: synchronous active-low rst_n clears head, busy flag, count and handshakes;
// queue RAM contents need no clearing.
module circular_look_disk_request_scheduler_unit
  import cldsch_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYLINDER_BITS = 14,
  parameter int TAG_BITS      = 8,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [CYLINDER_BITS-1:0] in_cylinder,
  input  logic [TAG_BITS-1:0]      in_tag,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_grant_valid,
  output logic [CYLINDER_BITS-1:0] out_grant_cylinder,
  output logic [TAG_BITS-1:0]      out_grant_tag,
  output logic [CYLINDER_BITS-1:0] out_seek_distance,
  output logic                     out_dropped,
  output logic [CW-1:0]            out_waiting_count
);

  localparam int DW = CYLINDER_BITS + TAG_BITS;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  cldsch_state_t state_r, state_nxt;

  logic [CYLINDER_BITS-1:0] head_r, head_nxt;
  logic                     busy_r, busy_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            iss_r, iss_nxt;
  logic                     pipe_vld_r, pipe_vld_nxt;
  logic [AW-1:0]            pipe_idx_r, pipe_idx_nxt;

  logic                     res_grant_r, res_grant_nxt;
  logic [CYLINDER_BITS-1:0] res_cyl_r, res_cyl_nxt;
  logic [TAG_BITS-1:0]      res_tag_r, res_tag_nxt;
  logic [CYLINDER_BITS-1:0] res_dist_r, res_dist_nxt;
  logic                     res_drop_r, res_drop_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_grant_r;
  logic [CYLINDER_BITS-1:0] out_cyl_r, out_dist_r;
  logic [TAG_BITS-1:0]      out_tag_r;
  logic                     out_drop_r;
  logic [CW-1:0]            out_cnt_r;

  logic                     in_acc, out_load, pipe_done;
  logic                     ram_wr_en;
  logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
  logic [DW-1:0]            ram_wr_data, ram_rd_data;
  pick_ctl_t                pick_ctl;
  logic [AW-1:0]            sel_idx;
  logic [CYLINDER_BITS-1:0] sel_cyl, new_cyl, new_dist;
  logic [TAG_BITS-1:0]      sel_tag;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);
  assign pipe_done = (iss_r == cnt_r) && !pipe_vld_r;

  // head moves to either the arriving cylinder or the selected slot
  assign new_cyl  = (state_r == ST_SCAN) ? sel_cyl : in_cylinder;
  assign new_dist = (new_cyl > head_r) ? (new_cyl - head_r) : (head_r - new_cyl);

  cldsch_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  cldsch_pick #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .CYLINDER_BITS (CYLINDER_BITS),
    .TAG_BITS      (TAG_BITS)
  ) u_pick (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (pick_ctl),
    .head    (head_r),
    .smp_idx (pipe_idx_r),
    .smp_cyl (ram_rd_data[DW-1:TAG_BITS]),
    .smp_tag (ram_rd_data[TAG_BITS-1:0]),
    .sel_idx (sel_idx),
    .sel_cyl (sel_cyl),
    .sel_tag (sel_tag)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_DONE && busy_r && cnt_r != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (pipe_done) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (pipe_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    head_nxt      = head_r;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    pipe_vld_nxt  = 1'b0;
    pipe_idx_nxt  = pipe_idx_r;
    res_grant_nxt = res_grant_r;
    res_cyl_nxt   = res_cyl_r;
    res_tag_nxt   = res_tag_r;
    res_dist_nxt  = res_dist_r;
    res_drop_nxt  = res_drop_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = cnt_r[AW-1:0];
    ram_wr_data   = {in_cylinder, in_tag};
    ram_rd_addr   = iss_r[AW-1:0];
    pick_ctl      = '{clear: 1'b0, sample: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_grant_nxt = 1'b0;
          res_cyl_nxt   = '0;
          res_tag_nxt   = '0;
          res_dist_nxt  = '0;
          res_drop_nxt  = 1'b0;
          if (in_req_type == REQ_ARRIVE) begin
            if (!busy_r) begin
              res_grant_nxt = 1'b1;
              res_cyl_nxt   = in_cylinder;
              res_tag_nxt   = in_tag;
              res_dist_nxt  = new_dist;
              head_nxt      = in_cylinder;
              busy_nxt      = 1'b1;
            end else if (cnt_r < DEPTH_CNT) begin
              ram_wr_en = 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              res_drop_nxt = 1'b1;
            end
          end else if (busy_r) begin
            if (cnt_r == '0) begin
              busy_nxt = 1'b0;
            end else begin
              iss_nxt        = '0;
              pick_ctl.clear = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        pick_ctl.sample = pipe_vld_r;
        if (iss_r < cnt_r) begin
          iss_nxt      = iss_r + 1'b1;
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = iss_r[AW-1:0];
        end
        if (pipe_done) begin
          res_grant_nxt = 1'b1;
          res_cyl_nxt   = sel_cyl;
          res_tag_nxt   = sel_tag;
          res_dist_nxt  = new_dist;
          head_nxt      = sel_cyl;
          // compaction starts with the slot just above the pick
          iss_nxt       = CW'(sel_idx) + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (iss_r < cnt_r) begin
          iss_nxt      = iss_r + 1'b1;
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = iss_r[AW-1:0];
        end
        if (pipe_vld_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pipe_idx_r - 1'b1;
          ram_wr_data = ram_rd_data;
        end
        if (pipe_done) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_RESULT: begin
        pipe_vld_nxt = 1'b0;
      end
      default: begin
        pipe_vld_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r       <= iss_nxt;
    pipe_idx_r  <= pipe_idx_nxt;
    res_grant_r <= res_grant_nxt;
    res_cyl_r   <= res_cyl_nxt;
    res_tag_r   <= res_tag_nxt;
    res_dist_r  <= res_dist_nxt;
    res_drop_r  <= res_drop_nxt;
    if (out_load) begin
      out_grant_r <= res_grant_r;
      out_cyl_r   <= res_cyl_r;
      out_tag_r   <= res_tag_r;
      out_dist_r  <= res_dist_r;
      out_drop_r  <= res_drop_r;
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_grant_valid    = out_grant_r;
  assign out_grant_cylinder = out_cyl_r;
  assign out_grant_tag      = out_tag_r;
  assign out_seek_distance  = out_dist_r;
  assign out_dropped        = out_drop_r;
  assign out_waiting_count  = out_cnt_r;

endmodule

### hdl/cldsch_checker.sv
// Port-level checks for the C-LOOK scheduler, bound to the top level.
module cldsch_checker #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int CYLINDER_BITS = 14,
  parameter int TAG_BITS      = 8,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_grant_valid,
  input logic [CYLINDER_BITS-1:0] out_grant_cylinder,
  input logic [TAG_BITS-1:0]      out_grant_tag,
  input logic [CYLINDER_BITS-1:0] out_seek_distance,
  input logic                     out_dropped,
  input logic [CW-1:0]            out_waiting_count
);

  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  // a request without a grant carries zeroed grant fields
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_grant_valid |->
      out_grant_cylinder == '0 && out_grant_tag == '0 && out_seek_distance == '0)
    else $error("grant fields nonzero without grant");

  // a drop only happens with a full queue and never with a grant
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_grant_valid && out_waiting_count == DEPTH_CNT)
    else $error("drop without full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_waiting_count <= DEPTH_CNT)
    else $error("waiting count above queue depth");

  // one request in flight: the input stalls right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_grant_cylinder)
      && $stable(out_grant_tag) && $stable(out_waiting_count))
    else $error("stalled result changed");

endmodule

bind circular_look_disk_request_scheduler_unit cldsch_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .CYLINDER_BITS (CYLINDER_BITS),
  .TAG_BITS      (TAG_BITS)
) u_cldsch_checker (.*);
